// ===== rtl/core/qvr_pkg.sv =====
// ---------------------------------------------------------------------------
// Quaternion vector rotation package
// Widths, stage records and shared types for the rotation pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

	localparam int QUAT_W = 16;
	localparam int VEC_W  = 16;
	localparam int ROT_W  = VEC_W + 1;

	localparam int PROD_W = QUAT_W + VEC_W;
	localparam int SQ_W   = 2 * QUAT_W;
	localparam int N_W    = SQ_W + 2;
	localparam int UV_W   = PROD_W + 2;
	localparam int CR_W   = PROD_W + 2;
	localparam int NUM_W  = 2 * QUAT_W + VEC_W + 5;
	localparam int A_W    = NUM_W + 1;
	localparam int D_W    = N_W + 1;
	localparam int R_W    = ((A_W > D_W + ROT_W) ? A_W : D_W + ROT_W) + 1;

	typedef struct packed {
		logic [R_W-1:0]   rem;
		logic [D_W-1:0]   den;
		logic [ROT_W-1:0] quo;
		logic             ovf;
		logic             neg;
		logic             zero;
	} div_stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/qvr_div.sv =====
// ---------------------------------------------------------------------------
// Pipelined rounding divider
// Restoring division, one quotient bit per stage, then saturation and sign.
// ---------------------------------------------------------------------------
`default_nettype none

module qvr_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [qvr_pkg::A_W-1:0]    num,
	input  wire logic [qvr_pkg::D_W-1:0]    den,
	input  wire logic                       neg,
	input  wire logic                       zero,
	output logic                            out_valid,
	output logic [qvr_pkg::ROT_W-1:0]       res,
	output logic                            res_zero
);
	import qvr_pkg::*;

	div_stage_t st_s [0:ROT_W];
	logic       vld_s [0:ROT_W];
	logic [ROT_W-1:0] limit;
	logic [ROT_W-1:0] mag;
	div_stage_t last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0].rem  <= R_W'(num);
			st_s[0].den  <= den;
			st_s[0].quo  <= '0;
			st_s[0].ovf  <= R_W'(num) >= (R_W'(den) << ROT_W);
			st_s[0].neg  <= neg;
			st_s[0].zero <= zero;
		end
	end

	for (genvar g = 0; g < ROT_W; g++) begin : g_bit
		localparam int B = ROT_W - 1 - g;
		logic [R_W-1:0] dsh;
		logic           take;
		assign dsh  = R_W'(st_s[g].den) << B;
		assign take = st_s[g].rem >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g+1].rem  <= take ? st_s[g].rem - dsh : st_s[g].rem;
				st_s[g+1].den  <= st_s[g].den;
				st_s[g+1].quo  <= st_s[g].quo | (ROT_W'(take) << B);
				st_s[g+1].ovf  <= st_s[g].ovf;
				st_s[g+1].neg  <= st_s[g].neg;
				st_s[g+1].zero <= st_s[g].zero;
			end
		end
	end

	assign last  = st_s[ROT_W];
	assign limit = last.neg ? ROT_W'(1) << (ROT_W - 1)
	                        : (ROT_W'(1) << (ROT_W - 1)) - ROT_W'(1);

	always_comb begin
		mag = (last.ovf || last.quo > limit) ? limit : last.quo;
		if (last.zero) begin
			res = '0;
		end else begin
			res = last.neg ? ROT_W'(-mag) : mag;
		end
	end

	assign out_valid = vld_s[ROT_W];
	assign res_zero  = last.zero;

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_vector_rotate.sv =====
// ---------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a 3D vector by a quaternion of any nonzero scale.
// ---------------------------------------------------------------------------
// Each input item carries a quaternion and a vector; each result item carries
// the rotated vector, rounded to nearest and saturated, and a flag that is set
// when the quaternion is zero (the vector is then zero).
// Both channels use valid and stall. An item is taken when valid is high and
// stall is low.
// From acceptance to a valid result an item passes four arithmetic
// stages (products, sums, products, final sum and rounding offset), one
// range check stage, one stage per quotient bit of the divider, and the
// output register.
// Throughput is one item per cycle while the output is not stalled; the whole pipeline advances together.
// When the receiver stalls a valid result, every stage holds and the input
// stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits; no result is shown until a new item arrives.
// ---------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [qvr_pkg::QUAT_W-1:0]  quat_i,
	input  wire logic signed [qvr_pkg::QUAT_W-1:0]  quat_j,
	input  wire logic signed [qvr_pkg::QUAT_W-1:0]  quat_k,
	input  wire logic signed [qvr_pkg::QUAT_W-1:0]  quat_real,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]   vec_x,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]   vec_y,
	input  wire logic signed [qvr_pkg::VEC_W-1:0]   vec_z,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [qvr_pkg::ROT_W-1:0]        rot_x,
	output logic signed [qvr_pkg::ROT_W-1:0]        rot_y,
	output logic signed [qvr_pkg::ROT_W-1:0]        rot_z,
	output logic                                    zero_quat
);
	import qvr_pkg::*;

	logic en;

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [SQ_W-1:0]   xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [PROD_W-1:0] xvx_s1, yvy_s1, zvz_s1;
	logic signed [PROD_W-1:0] yvz_s1, zvy_s1, zvx_s1, xvz_s1, xvy_s1, yvx_s1;
	logic signed [QUAT_W-1:0] x_s1, y_s1, z_s1, w_s1;
	logic signed [VEC_W-1:0]  vx_s1, vy_s1, vz_s1;

	logic signed [N_W-1:0]    n_s2, s_s2;
	logic signed [UV_W-1:0]   uv_s2;
	logic signed [CR_W-1:0]   cx_s2, cy_s2, cz_s2;
	logic signed [QUAT_W:0]   x2_s2, y2_s2, z2_s2, w2_s2;
	logic signed [VEC_W-1:0]  vx_s2, vy_s2, vz_s2;

	logic signed [NUM_W-1:0]  ax_s3, bx_s3, cxw_s3;
	logic signed [NUM_W-1:0]  ay_s3, by_s3, cyw_s3;
	logic signed [NUM_W-1:0]  az_s3, bz_s3, czw_s3;
	logic signed [N_W-1:0]    n_s3;

	logic signed [NUM_W-1:0]  numx, numy, numz;
	logic [NUM_W-1:0]         magx, magy, magz;
	logic [A_W-1:0]           ax_s4, ay_s4, az_s4;
	logic [D_W-1:0]           d_s4;
	logic                     nx_s4, ny_s4, nz_s4, zero_s4;

	logic                     dv_x, dv_y, dv_z;
	logic [ROT_W-1:0]         rx, ry, rz;
	logic                     zx, zy, zz;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1  <= quat_i * quat_i;
			yy_s1  <= quat_j * quat_j;
			zz_s1  <= quat_k * quat_k;
			ww_s1  <= quat_real * quat_real;
			xvx_s1 <= quat_i * vec_x;
			yvy_s1 <= quat_j * vec_y;
			zvz_s1 <= quat_k * vec_z;
			yvz_s1 <= quat_j * vec_z;
			zvy_s1 <= quat_k * vec_y;
			zvx_s1 <= quat_k * vec_x;
			xvz_s1 <= quat_i * vec_z;
			xvy_s1 <= quat_i * vec_y;
			yvx_s1 <= quat_j * vec_x;
			x_s1   <= quat_i;
			y_s1   <= quat_j;
			z_s1   <= quat_k;
			w_s1   <= quat_real;
			vx_s1  <= vec_x;
			vy_s1  <= vec_y;
			vz_s1  <= vec_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2  <= N_W'(xx_s1) + N_W'(yy_s1) + N_W'(zz_s1) + N_W'(ww_s1);
			s_s2  <= N_W'(ww_s1) - N_W'(xx_s1) - N_W'(yy_s1) - N_W'(zz_s1);
			uv_s2 <= UV_W'(xvx_s1) + UV_W'(yvy_s1) + UV_W'(zvz_s1);
			cx_s2 <= CR_W'(yvz_s1) - CR_W'(zvy_s1);
			cy_s2 <= CR_W'(zvx_s1) - CR_W'(xvz_s1);
			cz_s2 <= CR_W'(xvy_s1) - CR_W'(yvx_s1);
			x2_s2 <= {x_s1, 1'b0};
			y2_s2 <= {y_s1, 1'b0};
			z2_s2 <= {z_s1, 1'b0};
			w2_s2 <= {w_s1, 1'b0};
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			vz_s2 <= vz_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s3  <= uv_s2 * x2_s2;
			bx_s3  <= s_s2 * vx_s2;
			cxw_s3 <= cx_s2 * w2_s2;
			ay_s3  <= uv_s2 * y2_s2;
			by_s3  <= s_s2 * vy_s2;
			cyw_s3 <= cy_s2 * w2_s2;
			az_s3  <= uv_s2 * z2_s2;
			bz_s3  <= s_s2 * vz_s2;
			czw_s3 <= cz_s2 * w2_s2;
			n_s3   <= n_s2;
		end
	end

	assign numx = ax_s3 + bx_s3 + cxw_s3;
	assign numy = ay_s3 + by_s3 + cyw_s3;
	assign numz = az_s3 + bz_s3 + czw_s3;
	assign magx = numx[NUM_W-1] ? NUM_W'(-numx) : numx;
	assign magy = numy[NUM_W-1] ? NUM_W'(-numy) : numy;
	assign magz = numz[NUM_W-1] ? NUM_W'(-numz) : numz;

	// Rounding to nearest: quotient of (2|num| + n) by 2n.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s4   <= (A_W'(magx) << 1) + A_W'(unsigned'(n_s3));
			ay_s4   <= (A_W'(magy) << 1) + A_W'(unsigned'(n_s3));
			az_s4   <= (A_W'(magz) << 1) + A_W'(unsigned'(n_s3));
			d_s4    <= D_W'(unsigned'(n_s3)) << 1;
			nx_s4   <= numx[NUM_W-1];
			ny_s4   <= numy[NUM_W-1];
			nz_s4   <= numz[NUM_W-1];
			zero_s4 <= (n_s3 == '0);
		end
	end

	qvr_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (ax_s4),
		.den       (d_s4),
		.neg       (nx_s4),
		.zero      (zero_s4),
		.out_valid (dv_x),
		.res       (rx),
		.res_zero  (zx)
	);

	qvr_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (ay_s4),
		.den       (d_s4),
		.neg       (ny_s4),
		.zero      (zero_s4),
		.out_valid (dv_y),
		.res       (ry),
		.res_zero  (zy)
	);

	qvr_div u_div_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (az_s4),
		.den       (d_s4),
		.neg       (nz_s4),
		.zero      (zero_s4),
		.out_valid (dv_z),
		.res       (rz),
		.res_zero  (zz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_x && dv_y && dv_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_x     <= signed'(rx);
			rot_y     <= signed'(ry);
			rot_z     <= signed'(rz);
			zero_quat <= zx && zy && zz;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// Quaternion vector rotation testbench
// Drives quaternion and vector items through the rotation block with random
// idling on both channels, then with none, and checks every rotated vector
// against a local exact-integer predictor with round-half-away and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import qvr_pkg::*;

	typedef struct {
		logic signed [QUAT_W-1:0] qi, qj, qk, qr;
		logic signed [VEC_W-1:0]  vx, vy, vz;
	} rot_item_t;

	typedef struct {
		logic signed [ROT_W-1:0] rx, ry, rz;
		logic                    zq;
	} rot_result_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, zero_quat;
	logic in_held;
	logic signed [QUAT_W-1:0] quat_i, quat_j, quat_k, quat_real;
	logic signed [VEC_W-1:0]  vec_x, vec_y, vec_z;
	logic signed [ROT_W-1:0]  rot_x, rot_y, rot_z;

	rot_item_t   pending_items[$];
	rot_result_t expected_rotations[$];
	int          mismatch_count;
	int          send_idle_pct, recv_idle_pct;

	quaternion_vector_rotate DUT (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [ROT_W-1:0] round_quotient(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] mag, q, lim;
		logic neg;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (2 * mag + den) / (2 * den);
		lim = neg ? (128'sd1 <<< (ROT_W - 1)) : (128'sd1 <<< (ROT_W - 1)) - 1;
		if (q > lim)
			q = lim;
		return ROT_W'(neg ? -q : q);
	endfunction

	function automatic rot_result_t predict_rotation(rot_item_t t);
		logic signed [127:0] x, y, z, w, vx, vy, vz, uu, ww, n, uv, s, cx, cy, cz;
		rot_result_t r;
		x = 128'(t.qi); y = 128'(t.qj); z = 128'(t.qk); w = 128'(t.qr);
		vx = 128'(t.vx); vy = 128'(t.vy); vz = 128'(t.vz);
		uu = x * x + y * y + z * z;
		ww = w * w;
		n = uu + ww;
		if (n == 0) begin
			r.rx = '0; r.ry = '0; r.rz = '0; r.zq = 1'b1;
			return r;
		end
		uv = x * vx + y * vy + z * vz;
		s = ww - uu;
		cx = y * vz - z * vy;
		cy = z * vx - x * vz;
		cz = x * vy - y * vx;
		r.rx = round_quotient(2 * x * uv + s * vx + 2 * w * cx, n);
		r.ry = round_quotient(2 * y * uv + s * vy + 2 * w * cy, n);
		r.rz = round_quotient(2 * z * uv + s * vz + 2 * w * cz, n);
		r.zq = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("Mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_item(int qi, int qj, int qk, int qr, int vx, int vy, int vz);
		rot_item_t t;
		t.qi = QUAT_W'(qi); t.qj = QUAT_W'(qj); t.qk = QUAT_W'(qk); t.qr = QUAT_W'(qr);
		t.vx = VEC_W'(vx); t.vy = VEC_W'(vy); t.vz = VEC_W'(vz);
		pending_items.push_back(t);
	endtask

	function automatic int rand_quat();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 16) - 8;
			1: return $urandom_range(0, 512) - 256;
			2: return $urandom_range(0, 1) ? 32767 : -32768;
			default: return $signed(16'($urandom));
		endcase
	endfunction

	function automatic int rand_vec();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 200) - 100;
			1: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) :
				-32768 + $urandom_range(0, 3);
			default: return $signed(16'($urandom));
		endcase
	endfunction

	always @(posedge clk) begin
		in_held <= in_valid && in_stall;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			if (!in_held) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					rot_item_t t;
					t = pending_items.pop_front();
					quat_i <= t.qi; quat_j <= t.qj; quat_k <= t.qk; quat_real <= t.qr;
					vec_x <= t.vx; vec_y <= t.vy; vec_z <= t.vz;
					expected_rotations.push_back(predict_rotation(t));
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rotations.size() == 0) begin
				$display("Result item with nothing expected");
				mismatch_count++;
			end else begin
				rot_result_t e;
				e = expected_rotations.pop_front();
				if (rot_x !== e.rx) report_mismatch("rot_x", int'(rot_x), int'(e.rx));
				if (rot_y !== e.ry) report_mismatch("rot_y", int'(rot_y), int'(e.ry));
				if (rot_z !== e.rz) report_mismatch("rot_z", int'(rot_z), int'(e.rz));
				if (zero_quat !== e.zq)
					report_mismatch("zero_quat", int'(zero_quat), int'(e.zq));
			end
		end
	end

	initial begin
		#2000000;
		$display("Timeout");
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		mismatch_count = 0;
		send_idle_pct = 6;
		recv_idle_pct = 88;
		in_valid = 1'b0;
		out_stall = 1'b0;
		{quat_i, quat_j, quat_k, quat_real} = '0;
		{vec_x, vec_y, vec_z} = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		queue_item(0, 0, 0, 0, 123, -45, 6);
		queue_item(0, 0, 0, 0, -32768, 32767, -1);
		queue_item(0, 0, 0, 1, 32767, -32768, 100);
		queue_item(0, 0, 0, -32768, -32768, -32768, -32768);
		queue_item(32767, 0, 0, 0, 1, 2, 3);
		queue_item(0, -32768, 0, 0, 32767, 32767, 32767);
		queue_item(0, 0, 32767, 0, -32768, 32767, 0);
		queue_item(1, 1, 1, 1, 32767, 32767, 32767);
		queue_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
		queue_item(32767, 32767, 32767, 32767, 32767, -32768, 32767);
		queue_item(1, 0, 0, 1, 1, 0, 1);
		queue_item(1, 0, 0, 1, -1, 1, 0);
		queue_item(1, 1, 0, 1, 1, 0, 0);
		queue_item(1, 1, 0, 1, -1, 0, 0);
		queue_item(0, 0, 3, 1, 5, 0, 0);
		queue_item(0, 0, 1, 2, 3, 3, 0);
		queue_item(12345, -23456, 54, 30000, -32768, 32767, -32768);
		queue_item(-1, 2, -3, 4, 32767, 32767, 32767);
		queue_item(0, 0, 0, 0, 0, 0, 0);
		queue_item(0, 0, 0, 7, 0, 0, 0);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 88;
				recv_idle_pct = 6;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < 510; n++) begin
				if ($urandom_range(0, 49) == 0)
					queue_item(0, 0, 0, 0, rand_vec(), rand_vec(), rand_vec());
				else
					queue_item(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
						rand_vec(), rand_vec(), rand_vec());
			end
			wait (pending_items.size() == 0);
		end

		@(negedge clk);
		wait (!in_valid || !in_stall);
		@(posedge clk);
		wait (expected_rotations.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/qvr_pkg.sv
rtl/core/qvr_div.sv
rtl/core/quaternion_vector_rotate.sv
tb/tb_top.sv
